// ===== design/mbs_pkg.sv =====
// Package for the mean background segmenter.
// Holds frame geometry, field widths, mode codes and the controller/datapath
// command and status structs. No dependencies.
package mbs_pkg;

	localparam int FRAME_WIDTH  = 640;
	localparam int FRAME_HEIGHT = 480;
	localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int POS_W        = $clog2(PIXELS);

	localparam int PIX_W   = 8;
	localparam int CH_W    = 18;
	localparam int ENTRY_W = 3 * CH_W;
	localparam int CFG_W   = 10;
	localparam int FS_W    = CFG_W + 1;
	localparam int SUM_W   = 10;
	localparam int STEP_W  = $clog2(CH_W);

	localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);
	localparam logic [CFG_W-1:0] THRESH_RESET = CFG_W'(60);
	localparam logic [CH_W-1:0]  CH_SAT       = CH_W'(255);

	// configuration register indexes
	localparam logic CFG_FRAMES = 1'b0;
	localparam logic CFG_THRESH = 1'b1;

	// what an accepted item does
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_DROP = 2'd0;
	localparam mode_t MODE_CAL  = 2'd1;
	localparam mode_t MODE_DET  = 2'd2;

	typedef struct packed {
		logic accept;
		logic rd;
		logic latch_e;
		logic div_load;
		logic div_step;
		logic div_store;
		logic wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  first;
		logic  do_mean;
		logic  div_last;
		logic  ch_last;
		logic  out_free;
	} sts_t;

endpackage

// ===== design/mbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/mbs_ctrl.sv =====
// Controller state machine of the mean background segmenter.
// Depends on mbs_pkg for the command and status structs.
module mbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mbs_pkg::sts_t sts,
	output mbs_pkg::cmd_t cmd
);
	import mbs_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DISP    = 3'd1;
	localparam logic [2:0] S_READ    = 3'd2;
	localparam logic [2:0] S_LATCH   = 3'd3;
	localparam logic [2:0] S_DIVLOAD = 3'd4;
	localparam logic [2:0] S_DIV     = 3'd5;
	localparam logic [2:0] S_DIVEND  = 3'd6;
	localparam logic [2:0] S_WRITE   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_pend_q, out_pend_d;

	assign in_ready = (state_q == S_IDLE) && !out_pend_q;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		out_pend_d = out_pend_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (out_pend_q) begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						out_pend_d   = 1'b0;
					end
				end else if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.mode == MODE_DROP) begin
					state_d = S_IDLE;
				end else if (sts.mode == MODE_CAL && sts.first) begin
					state_d = sts.do_mean ? S_DIVLOAD : S_WRITE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_LATCH;
			end
			S_LATCH: begin
				cmd.latch_e = 1'b1;
				if (sts.mode == MODE_DET) begin
					out_pend_d = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = sts.do_mean ? S_DIVLOAD : S_WRITE;
				end
			end
			S_DIVLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DIVEND;
				end
			end
			S_DIVEND: begin
				cmd.div_store = 1'b1;
				state_d       = sts.ch_last ? S_WRITE : S_DIVLOAD;
			end
			S_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_pend_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			out_pend_q <= out_pend_d;
		end
	end
endmodule

// ===== design/mbs_dp.sv =====
// Datapath of the mean background segmenter: bookkeeping, configuration,
// pixel store, shared restoring divider and output register.
// Depends on mbs_pkg and mbs_ram.
module mbs_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mbs_pkg::PIX_W-1:0]   blue,
	input  logic [mbs_pkg::PIX_W-1:0]   green,
	input  logic [mbs_pkg::PIX_W-1:0]   red,
	input  logic                        start_of_frame,
	input  logic                        cfg_valid,
	input  logic                        cfg_index,
	input  logic [mbs_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        foreground,
	output logic [mbs_pkg::SUM_W-1:0]   difference_sum,
	output logic                        last_of_frame,
	input  mbs_pkg::cmd_t               cmd,
	output mbs_pkg::sts_t               sts
);
	import mbs_pkg::*;

	logic [CFG_W-1:0] frames_cfg_q, thresh_q;
	logic [POS_W-1:0] position_q, pos_q;
	logic [FS_W-1:0]  frames_q;
	logic             cal_q;
	mode_t            mode_q;
	logic             first_q, mean_q, last_q;
	logic [PIX_W-1:0] px_q [3];
	logic [ENTRY_W-1:0] e_q, rdata;
	logic [CH_W-1:0]  avg_q [3];
	logic [1:0]       ch_q;
	logic [CH_W-1:0]  dvd_q;
	logic [CFG_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic             out_valid_q;

	// accept-time decode
	logic [POS_W-1:0] pos_in, pos_next;
	logic [CFG_W-1:0] n;
	logic [FS_W-1:0]  fs_new, k;
	logic             cal_mid, cal_end, begins, is_last;
	mode_t            mode_d;

	always_comb begin
		pos_in   = start_of_frame ? '0 : position_q;
		begins   = (pos_in == '0);
		is_last  = (pos_in == POS_W'(PIXELS - 1));
		pos_next = is_last ? '0 : pos_in + POS_W'(1);
		n        = (frames_cfg_q == '0) ? CFG_W'(1) : frames_cfg_q;
		fs_new   = frames_q;
		cal_mid  = cal_q;
		if (cal_q && begins) begin
			if (frames_q >= {1'b0, n} + FS_W'(1)) begin
				cal_mid = 1'b0;
			end else begin
				fs_new = frames_q + FS_W'(1);
			end
		end
		k = (fs_new == '0) ? '0 : fs_new - FS_W'(1);
		if (!cal_mid) begin
			mode_d = MODE_DET;
		end else if (k == '0) begin
			mode_d = MODE_DROP;
		end else begin
			mode_d = MODE_CAL;
		end
		cal_end = cal_mid && !(mode_d == MODE_CAL && k >= {1'b0, n} && is_last);
	end

	// channel sums and saturated means
	logic [CH_W-1:0]  csum [3];
	logic [PIX_W-1:0] m8 [3], ad [3];
	logic [SUM_W-1:0] dsum;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			csum[c] = e_q[c*CH_W +: CH_W] + CH_W'(px_q[c]);
			m8[c]   = (e_q[c*CH_W +: CH_W] > CH_SAT) ? PIX_W'(255)
				: e_q[c*CH_W +: PIX_W];
			ad[c]   = (px_q[c] > m8[c]) ? px_q[c] - m8[c] : m8[c] - px_q[c];
		end
		dsum = SUM_W'(ad[0]) + SUM_W'(ad[1]) + SUM_W'(ad[2]);
	end

	// divider step and rounding
	logic [CFG_W:0]   rem_sh, rem2;
	logic             qbit, rnd_up;
	logic [CH_W-1:0]  rounded;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[CH_W-1]};
		qbit    = (rem_sh >= {1'b0, n});
		rem2    = {rem_q, 1'b0};
		rnd_up  = (rem2 > {1'b0, n}) || (rem2 == {1'b0, n} && dvd_q[0]);
		rounded = dvd_q + CH_W'(rnd_up);
	end

	// configuration and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_cfg_q <= FRAMES_RESET;
			thresh_q     <= THRESH_RESET;
			position_q   <= '0;
			frames_q     <= '0;
			cal_q        <= 1'b1;
			mode_q       <= MODE_DROP;
			ch_q         <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_FRAMES) begin
					frames_cfg_q <= cfg_data;
				end else begin
					thresh_q <= cfg_data;
				end
			end
			if (cmd.accept) begin
				position_q <= pos_next;
				frames_q   <= fs_new;
				cal_q      <= cal_end;
				mode_q     <= mode_d;
				ch_q       <= '0;
			end
			if (cmd.div_load) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.div_store) begin
				ch_q <= ch_q + 2'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q[0] <= blue;
			px_q[1] <= green;
			px_q[2] <= red;
			pos_q   <= pos_in;
			first_q <= (k == FS_W'(1));
			mean_q  <= (k >= {1'b0, n});
			last_q  <= is_last;
			e_q     <= '0;
		end else if (cmd.latch_e) begin
			e_q <= rdata;
		end
		if (cmd.div_load) begin
			dvd_q <= csum[ch_q];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? CFG_W'(rem_sh - {1'b0, n}) : rem_sh[CFG_W-1:0];
			dvd_q <= {dvd_q[CH_W-2:0], qbit};
		end
		if (cmd.div_store) begin
			avg_q[ch_q] <= rounded;
		end
		if (cmd.out_load) begin
			difference_sum <= dsum;
			foreground     <= (dsum > thresh_q);
			last_of_frame  <= last_q;
		end
	end

	// pixel store
	logic [ENTRY_W-1:0] wdata;
	assign wdata = mean_q ? {avg_q[2], avg_q[1], avg_q[0]} : {csum[2], csum[1], csum[0]};

	mbs_ram #(.WIDTH(ENTRY_W), .DEPTH(PIXELS)) u_store (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (pos_q),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (pos_q),
		.rdata (rdata)
	);

	assign out_valid    = out_valid_q;
	assign sts.mode     = mode_q;
	assign sts.first    = first_q;
	assign sts.do_mean  = mean_q;
	assign sts.div_last = (step_q == STEP_W'(CH_W - 1));
	assign sts.ch_last  = (ch_q == 2'd2);
	assign sts.out_free = !out_valid_q || out_ready;
endmodule

// ===== design/mean_background_segmenter.sv =====
// Top level of the mean background segmenter.
// Depends on mbs_pkg, mbs_ctrl and mbs_dp.
// The block takes one pixel at a time. A detection pixel is read and latched,
// and its result is loaded into the output register once that register is free.
// A calibration pixel is read, latched and written back; on the first averaging
// frame it is written without a read. On the frame that writes the mean, the
// time is set by the shared one-bit-per-cycle divider, run once per channel
// (18 steps plus load and store each) before the write. A pixel of the
// discarded first frame is dropped at dispatch. Every item makes at most one
// read and at most one write of the single pixel store. A detection result
// waits in an output register. The next item is accepted as soon as the
// previous result has moved into that register. While a result is still
// waiting for the register, the input is held off.
module mean_background_segmenter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mbs_pkg::PIX_W-1:0]   blue,
	input  logic [mbs_pkg::PIX_W-1:0]   green,
	input  logic [mbs_pkg::PIX_W-1:0]   red,
	input  logic                        start_of_frame,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        foreground,
	output logic [mbs_pkg::SUM_W-1:0]   difference_sum,
	output logic                        last_of_frame,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [mbs_pkg::CFG_W-1:0]   cfg_data
);
	import mbs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.start_of_frame (start_of_frame),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.foreground     (foreground),
		.difference_sum (difference_sum),
		.last_of_frame  (last_of_frame),
		.cmd            (cmd),
		.sts            (sts)
	);
endmodule

// ===== design/mbs_checker.sv =====
// Port-level checks for the mean background segmenter, bound to the top level.
// Depends on mbs_pkg for widths.
module mbs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      foreground,
	input logic [mbs_pkg::SUM_W-1:0] difference_sum,
	input logic                      last_of_frame
);
	import mbs_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(difference_sum)
			&& $stable(foreground) && $stable(last_of_frame))
		else $error("stalled result changed");

	// sum of three 8-bit differences stays in range
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> difference_sum <= SUM_W'(765))
		else $error("difference sum out of range");

	// foreground needs a nonzero difference
	a_fg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && foreground |-> difference_sum != '0)
		else $error("foreground with zero difference");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");
endmodule

bind mean_background_segmenter mbs_checker u_mbs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.foreground     (foreground),
	.difference_sum (difference_sum),
	.last_of_frame  (last_of_frame)
);
